FILE: rtl/cfb_pkg.sv
package cfb_pkg;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  port;
      logic [7:0]  prop;
      logic [7:0]  value;
      logic [7:0]  first_len;
      logic [7:0]  second_prop;
      logic [7:0]  second_len;
      logic [7:0]  second_value;
      logic [7:0]  init_type;
      logic [47:0] mac;
      logic [1:0]  factory_item;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_pending;
      logic last_byte;
   } dp_status_type;

   localparam logic [2:0] OP_GET     = 3'd0;
   localparam logic [2:0] OP_PUT     = 3'd1;
   localparam logic [2:0] OP_SETUP   = 3'd2;
   localparam logic [2:0] OP_INIT    = 3'd3;
   localparam logic [2:0] OP_MAC     = 3'd4;
   localparam logic [2:0] OP_FACTORY = 3'd5;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0]  SYNC_A   = 8'hFE;
   localparam logic [7:0]  SYNC_B   = 8'hFF;
   localparam logic [7:0]  FILL     = 8'hFF;
   localparam logic [7:0]  MAC_LEN  = 8'h0A;
   localparam logic [4:0]  PAYLOAD_START = 5'd5;

   function automatic logic op_known(input logic [2:0] op);
      op_known = (op <= OP_FACTORY);
   endfunction

   // Total frame length including sync, header and both CRC bytes.
   function automatic logic [4:0] frame_len(input logic [2:0] op);
      logic [4:0] len;
      case (op)
         OP_GET:     len = 5'd8;
         OP_PUT:     len = 5'd12;
         OP_SETUP:   len = 5'd15;
         OP_INIT:    len = 5'd9;
         OP_MAC:     len = 5'd17;
         OP_FACTORY: len = 5'd12;
         default:    len = 5'd8;
      endcase
      frame_len = len;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_byte = c;
   endfunction

   // Frame byte at a given position, up to but not including the CRC.
   function automatic logic [7:0] frame_byte(input req_type r, input logic [4:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         5'd0: b = SYNC_A;
         5'd1: b = SYNC_B;
         5'd2: begin
            case (r.op)
               OP_GET:  b = 8'h04;
               OP_INIT: b = r.init_type;
               default: b = 8'h03;
            endcase
         end
         5'd3: b = 8'h00;
         5'd4: begin
            case (r.op)
               OP_GET:   b = 8'h01;
               OP_SETUP: b = 8'h08;
               OP_INIT:  b = 8'h02;
               OP_MAC:   b = MAC_LEN;
               default:  b = 8'h05;
            endcase
         end
         default: begin
            case (r.op)
               OP_GET: b = r.port;
               OP_PUT: begin
                  case (idx)
                     5'd5:    b = r.port;
                     5'd6:    b = r.prop;
                     5'd7:    b = 8'h01;
                     5'd8:    b = r.value;
                     default: b = 8'h00;
                  endcase
               end
               OP_SETUP: begin
                  case (idx)
                     5'd5:    b = 8'h02;
                     5'd6:    b = r.prop;
                     5'd7:    b = r.first_len;
                     5'd8:    b = r.value;
                     5'd9:    b = r.second_prop;
                     5'd10:   b = r.second_len;
                     5'd11:   b = r.second_value;
                     default: b = 8'h00;
                  endcase
               end
               OP_INIT: begin
                  case (idx)
                     5'd5:    b = r.value;
                     default: b = 8'h00;
                  endcase
               end
               OP_MAC: begin
                  case (idx)
                     5'd5:    b = 8'h07;
                     5'd6:    b = 8'h01;
                     5'd7:    b = 8'h06;
                     5'd8:    b = r.mac[47:40];
                     5'd9:    b = r.mac[39:32];
                     5'd10:   b = r.mac[31:24];
                     5'd11:   b = r.mac[23:16];
                     5'd12:   b = r.mac[15:8];
                     5'd13:   b = r.mac[7:0];
                     default: b = 8'h00;
                  endcase
               end
               default: begin
                  // An unknown factory item leaves filler in its three slots.
                  case (idx)
                     5'd5:    b = 8'h04;
                     5'd6:    b = (r.factory_item == 2'd0) ? FILL : {6'd0, r.factory_item};
                     5'd7:    b = (r.factory_item == 2'd0) ? FILL : 8'h01;
                     5'd8:    b = (r.factory_item == 2'd0) ? FILL : r.value;
                     default: b = 8'h00;
                  endcase
               end
            endcase
         end
      endcase
      frame_byte = b;
   endfunction

endpackage

FILE: rtl/cfb_ctrl.sv
module cfb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [2:0]             req_op,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   input  cfb_pkg::dp_status_type status,
   output cfb_pkg::ctrl_cmd_type  cmd
);
   import cfb_pkg::*;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.load  = req_valid && req_ready;
   assign cmd.emit  = (state_ff == ST_SEND) && (!status.rsp_pending || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load && op_known(req_op)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (cmd.emit && status.last_byte) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_known_op_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && op_known(req_op)) |=> (state_ff == ST_SEND))
      else $error("known request did not start a frame");

   a_unknown_op_idles: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !op_known(req_op)) |=> (state_ff == ST_IDLE))
      else $error("unknown request started a frame");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last_byte) |=> req_ready)
      else $error("frame did not end after its last byte");

endmodule

FILE: rtl/cfb_datapath.sv
module cfb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  cfb_pkg::req_type       req_data,
   input  cfb_pkg::ctrl_cmd_type  cmd,
   output cfb_pkg::dp_status_type status,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output cfb_pkg::rsp_type       rsp_data
);
   import cfb_pkg::*;

   req_type     req_ff;
   logic [4:0]  byte_index_ff;
   logic [4:0]  byte_index_in;
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   logic [4:0]  total_len;
   logic [4:0]  payload_end;
   logic [7:0]  cur_byte;
   logic        cur_last;

   always_comb begin
      total_len   = frame_len(req_ff.op);
      payload_end = total_len - 5'd2;
      cur_last    = (byte_index_ff == total_len - 5'd1);
      if (byte_index_ff == payload_end) begin
         cur_byte = crc_ff[15:8];
      end else if (cur_last) begin
         cur_byte = crc_ff[7:0];
      end else begin
         cur_byte = frame_byte(req_ff, byte_index_ff);
      end
   end

   always_comb begin
      byte_index_in = byte_index_ff;
      crc_in        = crc_ff;
      if (cmd.load) begin
         byte_index_in = 5'd0;
         crc_in        = CRC_INIT;
      end else if (cmd.emit) begin
         byte_index_in = byte_index_ff + 5'd1;
         // Only the payload bytes go into the CRC.
         if (byte_index_ff >= PAYLOAD_START && byte_index_ff < payload_end) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 5'd0;
         crc_ff        <= CRC_INIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.emit) begin
         rsp_ff.frame_byte <= cur_byte;
         rsp_ff.last       <= cur_last;
      end
   end

   assign status.rsp_pending = rsp_valid_ff;
   assign status.last_byte   = cur_last;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("byte loaded over a transaction not yet taken");

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (byte_index_ff < total_len))
      else $error("byte index ran past the frame");

   a_index_restarts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (byte_index_ff == 5'd0) && (crc_ff == CRC_INIT))
      else $error("new request did not restart index and CRC");

endmodule

FILE: rtl/command_frame_builder_crc16_top.sv
// Builds one serial command frame per request and sends it one byte per
// transaction on the rsp_ channel, with last set on the closing CRC byte.
// A frame is FE FF, a type byte, 00, a length byte, the payload and a
// big-endian CRC-16 (poly 1021, init FFFF, MSB first, no final xor) over the
// payload. Frames are 8 to 17 bytes long depending on op; a request with op 6
// or 7 is accepted and produces nothing. A request is accepted, then its
// bytes go out one byte per cycle through the single output register while
// the receiver keeps taking them, during which req_ready is low.
// The next request is accepted while the final byte still waits to be taken.
module command_frame_builder_crc16_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cfb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfb_pkg::rsp_type rsp_data
);
   import cfb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   cfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/tb_command_frame_builder_crc16_top.sv
`timescale 1ns / 100ps

module tb_command_frame_builder_crc16_top;
   import cfb_pkg::*;

   // The two op codes that build no frame.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int STALL_LIMIT = 3000;

   class frame_board;
      rsp_type expected_bytes[$];
      int      mismatches = 0;
      int      bytes_checked = 0;
      int      requests_seen = 0;
      int      null_requests = 0;

      function logic [15:0] crc16_add(logic [15:0] crc, logic [7:0] data);
         logic [15:0] c;
         c = crc;
         for (int k = 7; k >= 0; k--) begin
            if (c[15] ^ data[k]) begin
               c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
               c = {c[14:0], 1'b0};
            end
         end
         return c;
      endfunction

      // Builds the frame that the block must send for one accepted request.
      function void note_request(req_type r);
         logic [7:0]  body[$];
         logic [7:0]  item_byte;
         logic [15:0] crc;
         rsp_type     b;
         requests_seen++;
         item_byte = {6'd0, r.factory_item};
         case (r.op)
            OP_GET: begin
               body = {8'h04, 8'h00, 8'h01, r.port};
            end
            OP_PUT: begin
               body = {8'h03, 8'h00, 8'h05, r.port, r.prop, 8'h01, r.value, 8'h00};
            end
            OP_SETUP: begin
               body = {8'h03, 8'h00, 8'h08, 8'h02, r.prop, r.first_len, r.value,
                       r.second_prop, r.second_len, r.second_value, 8'h00};
            end
            OP_INIT: begin
               body = {r.init_type, 8'h00, 8'h02, r.value, 8'h00};
            end
            OP_MAC: begin
               body = {8'h03, 8'h00, 8'h0A, 8'h07, 8'h01, 8'h06,
                       r.mac[47:40], r.mac[39:32], r.mac[31:24],
                       r.mac[23:16], r.mac[15:8], r.mac[7:0], 8'h00};
            end
            OP_FACTORY: begin
               // An unknown item keeps filler bytes, and they go into the CRC.
               if (r.factory_item == 2'd0) begin
                  body = {8'h03, 8'h00, 8'h05, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'h00};
               end else begin
                  body = {8'h03, 8'h00, 8'h05, 8'h04, item_byte, 8'h01, r.value, 8'h00};
               end
            end
            default: begin
               null_requests++;
               return;
            end
         endcase
         // The CRC covers the payload only, which begins after the length byte.
         crc = CRC_INIT;
         for (int i = 3; i < body.size(); i++) begin
            crc = crc16_add(crc, body[i]);
         end
         body.push_front(SYNC_B);
         body.push_front(SYNC_A);
         body.push_back(crc[15:8]);
         body.push_back(crc[7:0]);
         foreach (body[i]) begin
            b.frame_byte = body[i];
            b.last = (i == body.size() - 1);
            expected_bytes.push_back(b);
         end
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected frame byte: expected none, actual %h last %b",
                     $time, got.frame_byte, got.last);
            mismatches++;
            return;
         end
         want = expected_bytes.pop_front();
         bytes_checked++;
         if (got.frame_byte !== want.frame_byte) begin
            $display("%0t: frame_byte mismatch: expected %h, actual %h",
                     $time, want.frame_byte, got.frame_byte);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, got.last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   frame_board model;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int idle_run = 0;

   command_frame_builder_crc16_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Receiver: checks each byte transaction and stalls at random or on request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         model.check_byte(rsp_data);
      end
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      model.note_request(r);
   endtask

   // Stops offering requests until every expected byte has come back.
   task automatic wait_frames_done();
      req_valid <= 1'b0;
      do @(posedge clock); while (model.pending() != 0);
   endtask

   function automatic req_type uniform_request(input logic [2:0] op, input logic ones);
      req_type r;
      r = ones ? '1 : '0;
      r.op = op;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(99) < 6) begin
         r.op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else begin
         r.op = 3'($urandom_range(5, 0));
      end
      r.port = 8'($urandom_range(255));
      r.prop = 8'($urandom_range(255));
      r.value = 8'($urandom_range(255));
      r.first_len = 8'($urandom_range(255));
      r.second_prop = 8'($urandom_range(255));
      r.second_len = 8'($urandom_range(255));
      r.second_value = 8'($urandom_range(255));
      r.init_type = 8'($urandom_range(255));
      r.mac = {16'($urandom), $urandom};
      r.factory_item = 2'($urandom_range(3));
      return r;
   endfunction

   initial begin
      req_type r;
      model = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes for every kind, all factory items, unused codes.
      send_request(uniform_request(OP_GET, 1'b0));
      send_request(uniform_request(OP_GET, 1'b1));
      send_request(uniform_request(OP_PUT, 1'b0));
      send_request(uniform_request(OP_PUT, 1'b1));
      send_request(uniform_request(OP_SETUP, 1'b0));
      send_request(uniform_request(OP_SETUP, 1'b1));
      send_request(uniform_request(OP_INIT, 1'b0));
      send_request(uniform_request(OP_INIT, 1'b1));
      send_request(uniform_request(OP_MAC, 1'b0));
      send_request(uniform_request(OP_MAC, 1'b1));
      r = uniform_request(OP_MAC, 1'b0);
      r.mac = 48'h0123_4567_89AB;
      send_request(r);
      for (int item = 0; item < 4; item++) begin
         r = uniform_request(OP_FACTORY, 1'b0);
         r.factory_item = 2'(item);
         r.value = 8'hA5;
         send_request(r);
      end
      send_request(uniform_request(OP_SPARE_LO, 1'b1));
      send_request(uniform_request(OP_SPARE_HI, 1'b0));
      send_request(uniform_request(OP_GET, 1'b1));
      wait_frames_done();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 80 : 0;
         rsp_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 7 : 0;
         for (int n = 0; n < 68; n++) begin
            if (phase == 0 && n == 30) begin
               wait_frames_done();
            end
            // A long receiver stall while requests keep coming fills the block.
            if (phase == 2 && n == 10) begin
               hold_request = 150;
            end
            send_request(random_request());
         end
         wait_frames_done();
      end

      repeat (20) @(posedge clock);
      $display("tb: %0d requests (%0d with unused op codes) under mixed stalls, %0d bytes checked",
               model.requests_seen, model.null_requests, model.bytes_checked);
      if (model.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
